/* design/rrb_pkg.sv */
// ----------------------------------------------------------------------------
// rrb_pkg
// Shared types and constants for the retransmit ring buffer core.
// ----------------------------------------------------------------------------
package rrb_pkg;

    localparam int BUF_SIZE    = 4096;
    localparam int PTR_W       = $clog2(BUF_SIZE);
    localparam int MAX_BURST   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_ADVANCE = 3'd2;
    localparam logic [2:0] CMD_REWIND  = 3'd3;
    localparam logic [2:0] CMD_FLUSH   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_UNDERRUN  = 2'd2;
    localparam logic [1:0] ST_ACK_ERROR = 2'd3;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_ADVANCE,
        OP_REWIND,
        OP_FLUSH,
        OP_NOP
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  data_in;
        logic [4:0]  count;
        logic [11:0] ack_bytes;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_out;
        logic        last;
        logic [11:0] free_space;
        logic [11:0] available;
        logic        empty_res;
    } res_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data_in;
        logic [4:0]  count;
        logic [11:0] ack_bytes;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

/* design/rrb_front.sv */
// ----------------------------------------------------------------------------
// rrb_front
// Command intake: handshake with the issuer and decoding into operations.
// ----------------------------------------------------------------------------
module rrb_front (
    input  logic              start,
    input  rrb_pkg::cmd_t     item,
    input  rrb_pkg::q_stat_t  q_stat,
    output logic              busy,
    output logic              push,
    output rrb_pkg::q_entry_t push_data
);
    import rrb_pkg::*;

    op_t op;

    always_comb
    begin
        case (item.command)
            CMD_WRITE:   op = OP_WRITE;
            CMD_READ:    op = OP_READ;
            CMD_ADVANCE: op = OP_ADVANCE;
            CMD_REWIND:  op = OP_REWIND;
            CMD_FLUSH:   op = OP_FLUSH;
            default:     op = OP_NOP;
        endcase
    end

    assign busy                = q_stat.full;
    assign push                = start & ~q_stat.full;
    assign push_data.op        = op;
    assign push_data.data_in   = item.data_in;
    assign push_data.count     = item.count;
    assign push_data.ack_bytes = item.ack_bytes;

endmodule

/* design/rrb_queue.sv */
// ----------------------------------------------------------------------------
// rrb_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module rrb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rrb_pkg::q_entry_t push_data,
    input  logic              pop,
    output rrb_pkg::q_entry_t pop_data,
    output rrb_pkg::q_stat_t  q_stat
);
    import rrb_pkg::*;

    q_entry_t            entry_reg [QUEUE_DEPTH];
    logic [QIDX_W-1:0]   wr_ptr_reg;
    logic [QIDX_W-1:0]   wr_ptr_next;
    logic [QIDX_W-1:0]   rd_ptr_reg;
    logic [QIDX_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   fill_reg;
    logic [QCNT_W-1:0]   fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (fill_reg == '0);

endmodule

/* design/rrb_back.sv */
// ----------------------------------------------------------------------------
// rrb_back
// Execution part: byte store, the three ring pointers and result generation.
// ----------------------------------------------------------------------------
module rrb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rrb_pkg::q_stat_t  q_stat,
    input  rrb_pkg::q_entry_t pop_data,
    output logic              pop,
    output logic              result_valid,
    output rrb_pkg::res_t     result
);
    import rrb_pkg::*;

    logic [7:0]        store_mem [BUF_SIZE];

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  wp_next;
    logic [PTR_W-1:0]  ap_reg;
    logic [PTR_W-1:0]  ap_next;
    logic [PTR_W-1:0]  sp_reg;
    logic [PTR_W-1:0]  sp_next;
    logic [4:0]        remain_reg;
    logic [4:0]        remain_next;
    logic              valid_reg;
    logic              valid_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              last_reg;
    logic              last_next;
    logic              rd_flag_reg;
    logic              rd_flag_next;
    logic [7:0]        rd_data_reg;

    logic              mem_we;
    logic              mem_re;
    logic [PTR_W-1:0]  stored;
    logic [PTR_W-1:0]  avail;
    logic [PTR_W-1:0]  to_send;
    logic [PTR_W-1:0]  ap_adv;

    assign stored  = wp_reg - ap_reg;
    assign avail   = wp_reg - sp_reg;
    assign to_send = sp_reg - ap_reg;
    assign ap_adv  = ap_reg + pop_data.ack_bytes[PTR_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        ap_next      = ap_reg;
        sp_next      = sp_reg;
        remain_next  = remain_reg;
        valid_next   = 1'b0;
        status_next  = ST_OK;
        last_next    = 1'b1;
        rd_flag_next = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        pop          = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    valid_next = 1'b1;
                    case (pop_data.op)
                        OP_WRITE:
                        begin
                            if (stored == PTR_W'(BUF_SIZE - 1))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we  = 1'b1;
                                wp_next = wp_reg + 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (pop_data.count == '0)
                            begin
                                status_next = ST_OK;
                            end
                            else if (pop_data.count > 5'(MAX_BURST)
                                     || PTR_W'(pop_data.count) > avail)
                            begin
                                status_next = ST_UNDERRUN;
                            end
                            else
                            begin
                                mem_re       = 1'b1;
                                rd_flag_next = 1'b1;
                                sp_next      = sp_reg + 1'b1;
                                remain_next  = pop_data.count - 1'b1;
                                if (pop_data.count != 5'd1)
                                begin
                                    last_next  = 1'b0;
                                    state_next = BK_READ;
                                end
                            end
                        end
                        OP_ADVANCE:
                        begin
                            if (pop_data.ack_bytes > 12'(stored))
                            begin
                                status_next = ST_ACK_ERROR;
                            end
                            else
                            begin
                                ap_next = ap_adv;
                                if (pop_data.ack_bytes > 12'(to_send))
                                begin
                                    sp_next = ap_adv;
                                end
                            end
                        end
                        OP_REWIND:
                        begin
                            sp_next = ap_reg;
                        end
                        OP_FLUSH:
                        begin
                            wp_next = '0;
                            ap_next = '0;
                            sp_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                valid_next   = 1'b1;
                mem_re       = 1'b1;
                rd_flag_next = 1'b1;
                sp_next      = sp_reg + 1'b1;
                remain_next  = remain_reg - 1'b1;
                if (remain_reg == 5'd1)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    last_next = 1'b0;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            wp_reg      <= '0;
            ap_reg      <= '0;
            sp_reg      <= '0;
            remain_reg  <= '0;
            valid_reg   <= 1'b0;
            status_reg  <= ST_OK;
            last_reg    <= 1'b0;
            rd_flag_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            ap_reg      <= ap_next;
            sp_reg      <= sp_next;
            remain_reg  <= remain_next;
            valid_reg   <= valid_next;
            status_reg  <= status_next;
            last_reg    <= last_next;
            rd_flag_reg <= rd_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[wp_reg] <= pop_data.data_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= store_mem[sp_reg];
        end
    end

    // pointer registers hold the post-step state while the beat is shown
    assign result_valid      = valid_reg;
    assign result.status     = status_reg;
    assign result.data_out   = rd_flag_reg ? rd_data_reg : 8'd0;
    assign result.last       = last_reg;
    assign result.free_space = 12'(PTR_W'(BUF_SIZE - 1) - stored);
    assign result.available  = 12'(avail);
    assign result.empty_res  = (ap_reg == wp_reg);

endmodule

/* design/retransmit_ring_buffer_core.sv */
// ----------------------------------------------------------------------------
// retransmit_ring_buffer_core
// Byte ring buffer for retransmission with write, acknowledged and send
// pointers.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and raise start; the beat is taken at a
//   rising edge with start high and busy low. busy rises only when the
//   two-entry command queue is full.
//   Result channel: result_valid marks a beat on result for one cycle; the
//   receiver cannot stall, every beat must be taken as it appears.
//   Order: a taken command is written into the queue, popped when the
//   execution part is idle, and its result is registered before it shows;
//   it waits in the queue while a read burst or older commands are ahead.
//   Throughput: one command per cycle while busy is low and no read burst
//   is running; a read burst holds the execution stage until its last byte,
//   one byte per cycle from the byte store; later results follow in order.
//   Every result reports free space, available bytes and empty after its own
//   step.
//   Reset: pointers go to zero and the queue empties; the byte store keeps
//   its contents and is only read where written. No clearing pass.
// ----------------------------------------------------------------------------
module retransmit_ring_buffer_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rrb_pkg::cmd_t item,
    output logic          busy,
    output logic          result_valid,
    output rrb_pkg::res_t result
);
    import rrb_pkg::*;

    q_stat_t  q_stat;
    q_entry_t push_data;
    q_entry_t pop_data;
    logic     push;
    logic     pop;

    rrb_front u_front (
        .start     (start),
        .item      (item),
        .q_stat    (q_stat),
        .busy      (busy),
        .push      (push),
        .push_data (push_data)
    );

    rrb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    rrb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the retransmit ring buffer core. Drives commands through the
// start/busy handshake, predicts every result beat from a local copy of the
// ring and its three pointers, and checks each beat field by field. Covers
// the directed corner cases and a weighted random command mix with random
// sender gaps.
// ----------------------------------------------------------------------------
module tb_top;
    import rrb_pkg::*;

    localparam int GAP_MAX     = 17;
    localparam int STALL_LIMIT = 1000;

    logic clk;
    logic rst_n;
    logic start;
    cmd_t item;
    logic busy;
    logic result_valid;
    res_t result;

    retransmit_ring_buffer_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    // ring shadow
    logic [7:0]  ring_mem [0:BUF_SIZE-1];
    logic [11:0] wr_ptr;
    logic [11:0] ack_ptr;
    logic [11:0] snd_ptr;

    res_t pending_beats [$];
    int   fail_cnt;
    int   cmd_cnt;
    int   beat_cnt;
    int   reject_cnt;
    int   stall_cycles;
    bit   gaps_on;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [11:0] held_bytes();
        return wr_ptr - ack_ptr;
    endfunction

    function automatic logic [11:0] sendable_bytes();
        return wr_ptr - snd_ptr;
    endfunction

    function automatic cmd_t mk_cmd(logic [2:0] op, logic [7:0] data, logic [4:0] cnt,
                                    logic [11:0] ack);
        cmd_t c;
        c.command   = op;
        c.data_in   = data;
        c.count     = cnt;
        c.ack_bytes = ack;
        return c;
    endfunction

    task automatic push_beat(logic [1:0] st, logic [7:0] data, logic lst);
        res_t r;
        r.status     = st;
        r.data_out   = data;
        r.last       = lst;
        r.free_space = 12'hFFF - held_bytes();
        r.available  = sendable_bytes();
        r.empty_res  = (ack_ptr == wr_ptr);
        pending_beats.push_back(r);
    endtask

    task automatic predict_ring(cmd_t c);
        logic [11:0] to_send;
        int          n;
        n = c.count;
        case (c.command)
            CMD_WRITE:
            begin
                if (held_bytes() == 12'hFFF)
                    push_beat(ST_FULL, 8'h00, 1'b1);
                else
                begin
                    ring_mem[wr_ptr] = c.data_in;
                    wr_ptr = wr_ptr + 12'd1;
                    push_beat(ST_OK, 8'h00, 1'b1);
                end
            end
            CMD_READ:
            begin
                if (n == 0)
                    push_beat(ST_OK, 8'h00, 1'b1);
                else if (n > MAX_BURST || n > int'(sendable_bytes()))
                    push_beat(ST_UNDERRUN, 8'h00, 1'b1);
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        logic [7:0] b;
                        b = ring_mem[snd_ptr];
                        snd_ptr = snd_ptr + 12'd1;
                        push_beat(ST_OK, b, i == n - 1);
                    end
                end
            end
            CMD_ADVANCE:
            begin
                to_send = snd_ptr - ack_ptr;
                if (c.ack_bytes > held_bytes())
                    push_beat(ST_ACK_ERROR, 8'h00, 1'b1);
                else
                begin
                    ack_ptr = ack_ptr + c.ack_bytes;
                    if (c.ack_bytes > to_send)
                        snd_ptr = ack_ptr;
                    push_beat(ST_OK, 8'h00, 1'b1);
                end
            end
            CMD_REWIND:
            begin
                snd_ptr = ack_ptr;
                push_beat(ST_OK, 8'h00, 1'b1);
            end
            CMD_FLUSH:
            begin
                wr_ptr  = '0;
                ack_ptr = '0;
                snd_ptr = '0;
                push_beat(ST_OK, 8'h00, 1'b1);
            end
            default:
                push_beat(ST_OK, 8'h00, 1'b1);
        endcase
    endtask

    // one command beat; start stays high if the next call has no gap
    task automatic send_cmd(cmd_t c);
        int gap;
        gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        item  = c;
        do
            @(posedge clk);
        while (busy);
        predict_ring(c);
        cmd_cnt++;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && result_valid)
        begin
            beat_cnt++;
            if (result.status != ST_OK)
                reject_cnt++;
            if (pending_beats.size() == 0)
            begin
                $error("unexpected result beat: %p", result);
                fail_cnt++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    fail_cnt++;
                end
                if (result.data_out !== want.data_out)
                begin
                    $error("data_out: expected %0h, got %0h", want.data_out, result.data_out);
                    fail_cnt++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    fail_cnt++;
                end
                if (result.free_space !== want.free_space)
                begin
                    $error("free_space: expected %0d, got %0d", want.free_space,
                           result.free_space);
                    fail_cnt++;
                end
                if (result.available !== want.available)
                begin
                    $error("available: expected %0d, got %0d", want.available,
                           result.available);
                    fail_cnt++;
                end
                if (result.empty_res !== want.empty_res)
                begin
                    $error("empty_res: expected %0d, got %0d", want.empty_res,
                           result.empty_res);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: timeout, no beat moved for %0d cycles", STALL_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        send_cmd(mk_cmd(CMD_READ, 8'h00, 5'd0, 12'd0));
        send_cmd(mk_cmd(CMD_READ, 8'h00, 5'd1, 12'd0));
        send_cmd(mk_cmd(CMD_ADVANCE, 8'h00, 5'd0, 12'd1));
        send_cmd(mk_cmd(CMD_WRITE, 8'h00, 5'd0, 12'd0));
        send_cmd(mk_cmd(CMD_WRITE, 8'hFF, 5'd31, 12'hFFF));
        send_cmd(mk_cmd(CMD_WRITE, 8'hA5, 5'd0, 12'd0));
        send_cmd(mk_cmd(CMD_WRITE, 8'h5A, 5'd0, 12'd0));
        send_cmd(mk_cmd(CMD_READ, 8'h00, 5'd31, 12'd0));
        send_cmd(mk_cmd(CMD_READ, 8'h00, 5'd17, 12'd0));
        send_cmd(mk_cmd(CMD_READ, 8'h00, 5'd5, 12'd0));
        send_cmd(mk_cmd(CMD_READ, 8'h00, 5'd3, 12'd0));
        send_cmd(mk_cmd(CMD_ADVANCE, 8'h00, 5'd0, 12'd0));
        send_cmd(mk_cmd(CMD_REWIND, 8'h00, 5'd0, 12'd0));
        send_cmd(mk_cmd(CMD_READ, 8'h00, 5'd4, 12'd0));
        send_cmd(mk_cmd(CMD_ADVANCE, 8'h00, 5'd0, 12'd2));
        send_cmd(mk_cmd(CMD_REWIND, 8'h00, 5'd0, 12'd0));
        send_cmd(mk_cmd(CMD_ADVANCE, 8'h00, 5'd0, 12'd5));
        // acknowledge past the send pointer
        send_cmd(mk_cmd(CMD_ADVANCE, 8'h00, 5'd0, 12'd2));
        send_cmd(mk_cmd(3'd5, 8'hFF, 5'd31, 12'hFFF));
        send_cmd(mk_cmd(3'd6, 8'h00, 5'd0, 12'd0));
        send_cmd(mk_cmd(3'd7, 8'h00, 5'd0, 12'd0));
        send_cmd(mk_cmd(CMD_WRITE, 8'h3C, 5'd0, 12'd0));
        send_cmd(mk_cmd(CMD_FLUSH, 8'h00, 5'd0, 12'd0));
        send_cmd(mk_cmd(CMD_READ, 8'h00, 5'd1, 12'd0));
    endtask

    task automatic test_random(int n_cmds);
        cmd_t c;
        int   pick;
        int   lim;
        for (int i = 0; i < n_cmds; i++)
        begin
            if (i % 25 == 0)
                gaps_on = $urandom_range(0, 2) != 0;
            c    = cmd_t'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                c.command = CMD_WRITE;
            else if (pick < 65)
            begin
                c.command = CMD_READ;
                lim = (sendable_bytes() > MAX_BURST) ? MAX_BURST : int'(sendable_bytes());
                if (lim > 0 && $urandom_range(0, 3) != 0)
                    c.count = 5'($urandom_range(1, lim));
            end
            else if (pick < 80)
            begin
                c.command = CMD_ADVANCE;
                if ($urandom_range(0, 3) != 0)
                    c.ack_bytes = 12'($urandom_range(0, int'(held_bytes())));
            end
            else if (pick < 88)
                c.command = CMD_REWIND;
            else if (pick < 91)
                c.command = CMD_FLUSH;
            else if (pick < 94)
                c.command = 3'($urandom_range(5, 7));
            send_cmd(c);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        cmd_cnt      = 0;
        gaps_on      = 1'b1;
        wr_ptr       = '0;
        ack_ptr      = '0;
        snd_ptr      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        wait_drain();
        test_random(106);

        wait_drain();
        repeat (8) @(posedge clk);
        $display("tb_top: %0d commands sent, %0d result beats checked, %0d rejections",
                 cmd_cnt, beat_cnt, reject_cnt);
        $display("tb_top: covered rejections, burst limits, late acknowledge, rewind, flush");
        if (fail_cnt == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/rrb_pkg.sv
design/rrb_front.sv
design/rrb_queue.sv
design/rrb_back.sv
design/retransmit_ring_buffer_core.sv
test/tb_top.sv
